// ===== hw/rtl/ptd_pkg.sv =====
package ptd_pkg;

    // Width of the number port and of the internal datapath
    localparam int NUM_W = 32;
    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH + 1);

    localparam logic [WIDTH-1:0] TWO   = WIDTH'(2);
    localparam logic [WIDTH-1:0] THREE = WIDTH'(3);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic next_div;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic lt2;
        logic is_two_three;
        logic even;
        logic div_done;
        logic bound_over;
        logic rem_zero;
    } stat_t;

endpackage

// ===== hw/rtl/ptd_dp.sv =====
module ptd_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ptd_pkg::NUM_W-1:0] number,
    input  ptd_pkg::cmd_t             cmd,
    output ptd_pkg::stat_t            stat
);
    import ptd_pkg::*;

    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] d_reg;
    logic [WIDTH-1:0] q_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [WIDTH:0]   r2;
    logic             ge;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] q_next;

    // One restoring division step: bring down the next dividend bit
    always_comb
    begin
        r2       = {rem_reg, q_reg[WIDTH-1]};
        ge       = r2 >= {1'b0, d_reg};
        rem_next = ge ? WIDTH'(r2 - {1'b0, d_reg}) : r2[WIDTH-1:0];
        q_next   = {q_reg[WIDTH-2:0], ge};
    end

    // Hold the number, the trial divisor and the divider state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            d_reg   <= THREE;
        end
        else
        begin
            if (cmd.load)
            begin
                d_reg <= THREE;
            end
            else if (cmd.next_div)
            begin
                d_reg <= d_reg + TWO;
            end
            if (cmd.div_start)
            begin
                cnt_reg <= CNT_W'(WIDTH);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= WIDTH'(number);
        end
        if (cmd.div_start)
        begin
            q_reg   <= n_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    // Report classification and division outcome
    always_comb
    begin
        stat.lt2          = n_reg < TWO;
        stat.is_two_three = (n_reg == TWO) || (n_reg == THREE);
        stat.even         = ~n_reg[0];
        stat.div_done     = cnt_reg == '0;
        stat.bound_over   = q_reg < d_reg;
        stat.rem_zero     = rem_reg == '0;
    end

`ifndef ASSERT_OFF
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.div_step) |-> rem_reg < d_reg)
        else $error("remainder not below divisor after a division step");

    a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
        d_reg[0] == 1'b1)
        else $error("trial divisor is even");
`endif

endmodule

// ===== hw/rtl/ptd_ctrl.sv =====
module ptd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ptd_pkg::stat_t stat,
    output ptd_pkg::cmd_t  cmd,
    input  logic           out_free,
    output logic           out_load,
    output logic           verdict
);
    import ptd_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        CLASSIFY,
        DIVIDE,
        EVAL,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   verdict_reg;
    logic   verdict_next;

    // Sequence one item through classification and the trial loop
    always_comb
    begin
        state_next    = state_reg;
        verdict_next  = verdict_reg;
        cmd           = '0;
        out_load      = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CLASSIFY;
                end
            end
            CLASSIFY:
            begin
                if (stat.lt2)
                begin
                    verdict_next = 1'b0;
                    state_next   = FINISH;
                end
                else if (stat.is_two_three)
                begin
                    verdict_next = 1'b1;
                    state_next   = FINISH;
                end
                else if (stat.even)
                begin
                    verdict_next = 1'b0;
                    state_next   = FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = DIVIDE;
                end
            end
            DIVIDE:
            begin
                if (stat.div_done)
                begin
                    state_next = EVAL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            EVAL:
            begin
                // divisor above n/divisor: no factor left to find
                if (stat.bound_over)
                begin
                    verdict_next = 1'b1;
                    state_next   = FINISH;
                end
                else if (stat.rem_zero)
                begin
                    verdict_next = 1'b0;
                    state_next   = FINISH;
                end
                else
                begin
                    cmd.next_div  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = DIVIDE;
                end
            end
            FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            verdict_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
        end
    end

    assign in_stall = state_reg != IDLE;
    assign verdict  = verdict_reg;

`ifndef ASSERT_OFF
    a_load_to_classify: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == CLASSIFY)
        else $error("accepted item did not move to classification");

    a_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_step && (cmd.next_div || cmd.div_start)))
        else $error("division step overlaps divisor update");
`endif

endmodule

// ===== hw/rtl/prime_test_trial_division_top.sv =====
// Trial-division primality test. Each item carries one 32-bit unsigned
// number; exactly one item comes back with is_prime set when the number is
// prime. Zero, one, two, three and the other even numbers are settled by
// classification alone. Odd numbers from five upward are tested against the
// odd divisors 3, 5, 7 and upward to the square root; each trial divisor
// goes through a bit-serial restoring divider that gives quotient and
// remainder together. A 32-bit prime near the top of the range therefore
// needs some 32768 trial divisors. One item is worked on at a time; the
// result waits in an output register, and the next item is taken once the
// result has been placed there.
module prime_test_trial_division_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [ptd_pkg::NUM_W-1:0] number,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      is_prime
);
    import ptd_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  out_free;
    logic  out_load;
    logic  verdict;
    logic  out_valid_reg;
    logic  is_prime_reg;

    ptd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd),
        .out_free (out_free),
        .out_load (out_load),
        .verdict  (verdict)
    );

    ptd_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number),
        .cmd    (cmd),
        .stat   (stat)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            is_prime_reg <= verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule
